### src/stepper_valve_position_driver_unit_assert.svh
// Assertion shorthands for the stepper valve driver.
// Both expect clk and rst_n in scope and are off while reset is low.
`ifndef STEPPER_VALVE_POSITION_DRIVER_UNIT_ASSERT_SVH
`define STEPPER_VALVE_POSITION_DRIVER_UNIT_ASSERT_SVH

// Property that holds at every sampled edge.
`define SVPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequence checked by a non-overlapping implication from the antecedent.
`define SVPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/svpd_pkg.sv
package svpd_pkg;

  localparam int POSITION_BITS_DEF = 10;

  localparam int TARGET_W    = 10;
  localparam int NOW_W       = 32;
  localparam int HOLD_W      = 16;
  localparam int COIL_W      = 4;
  localparam int POS_FIELD_W = 10;
  localparam int PHASE_W     = 2;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;

  localparam logic [HOLD_W-1:0] HOLD_TIME_RST = 16'd600;

  localparam logic [PHASE_W-1:0] ST_SLEEP = 2'd0;
  localparam logic [PHASE_W-1:0] ST_START = 2'd1;
  localparam logic [PHASE_W-1:0] ST_RUN   = 2'd2;
  localparam logic [PHASE_W-1:0] ST_STOP  = 2'd3;

  localparam logic OP_CALL = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Controller state that travels between the top level and the step logic.
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [COIL_W-1:0]  coils;
    logic               armed;
    logic [NOW_W-1:0]   hold_start;
  } ctl_t;

  // Half-step order A, AB, B, BC, C, CD, D, DA.
  function automatic logic [COIL_W-1:0] beat_coils(input logic [2:0] idx);
    logic [COIL_W-1:0] c;
    case (idx)
      3'd0: c = 4'h1;
      3'd1: c = 4'h3;
      3'd2: c = 4'h2;
      3'd3: c = 4'h6;
      3'd4: c = 4'h4;
      3'd5: c = 4'hC;
      3'd6: c = 4'h8;
      3'd7: c = 4'h9;
      default: c = 4'h0;
    endcase
    return c;
  endfunction

endpackage

### src/svpd_step.sv
module svpd_step #(
  parameter int POSITION_BITS = svpd_pkg::POSITION_BITS_DEF
) (
  input  svpd_pkg::ctl_t                      ctl_i,
  input  logic [POSITION_BITS-1:0]            pos_i,
  input  logic                                op_i,
  input  logic [svpd_pkg::TARGET_W-1:0]       target_i,
  input  logic [svpd_pkg::NOW_W-1:0]          now_i,
  input  logic [svpd_pkg::HOLD_W-1:0]         hold_time_i,
  output svpd_pkg::ctl_t                      ctl_nxt,
  output logic [POSITION_BITS-1:0]            pos_nxt
);

  localparam int CW = (POSITION_BITS > svpd_pkg::TARGET_W) ? POSITION_BITS
                                                           : svpd_pkg::TARGET_W;
  localparam logic [CW-1:0] POS_MAX = CW'((64'd1 << POSITION_BITS) - 64'd1);
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  logic [CW-1:0]                 tgt_ext;
  logic [CW-1:0]                 tgt_sat;
  logic [CW-1:0]                 pos_ext;
  logic [svpd_pkg::NOW_W-1:0]    elapsed;
  logic                          expired;

  assign tgt_ext = CW'(target_i);
  assign tgt_sat = (tgt_ext > POS_MAX) ? POS_MAX : tgt_ext;
  assign pos_ext = CW'(pos_i);
  assign elapsed = now_i - ctl_i.hold_start;
  assign expired = elapsed > svpd_pkg::NOW_W'(hold_time_i);

  always_comb begin
    ctl_nxt = ctl_i;
    pos_nxt = pos_i;
    if (op_i == svpd_pkg::OP_LOAD) begin
      pos_nxt = tgt_ext[POSITION_BITS-1:0];
    end else begin
      case (ctl_i.phase)
        svpd_pkg::ST_SLEEP: begin
          if (pos_ext != tgt_sat) begin
            ctl_nxt.phase = svpd_pkg::ST_START;
          end
        end
        svpd_pkg::ST_START: begin
          ctl_nxt.coils = svpd_pkg::beat_coils(pos_i[2:0]);
          if (!ctl_i.armed) begin
            ctl_nxt.armed      = 1'b1;
            ctl_nxt.hold_start = now_i;
          end else if (expired) begin
            ctl_nxt.armed = 1'b0;
            ctl_nxt.phase = svpd_pkg::ST_RUN;
          end
        end
        svpd_pkg::ST_RUN: begin
          if (pos_ext > tgt_sat) begin
            pos_nxt       = pos_i - POS_ONE;
            ctl_nxt.coils = svpd_pkg::beat_coils(pos_nxt[2:0]);
          end else if (pos_ext < tgt_sat) begin
            pos_nxt       = pos_i + POS_ONE;
            ctl_nxt.coils = svpd_pkg::beat_coils(pos_nxt[2:0]);
          end else begin
            ctl_nxt.phase = svpd_pkg::ST_STOP;
          end
        end
        default: begin
          if (!ctl_i.armed) begin
            ctl_nxt.armed      = 1'b1;
            ctl_nxt.hold_start = now_i;
          end else if (expired) begin
            ctl_nxt.armed = 1'b0;
            ctl_nxt.coils = '0;
            ctl_nxt.phase = svpd_pkg::ST_SLEEP;
          end
        end
      endcase
    end
  end

endmodule

### src/stepper_valve_position_driver_unit.sv
// Stepper valve position driver: four-coil half-step drive toward a target.
// Input stream: one beat per controller call. in_tuser is the op flag
// (0 = controller call, 1 = load the position counter); in_tdata carries
// target_open and the millisecond time stamp now_ms. Every input beat
// yields exactly one output beat with the coil drive, the position after
// the call and the controller phase.
// Config channel: cfg_data writes hold_time_ms; always ready, write it only
// while the block is idle.
// Output is registered after the step logic. Throughput: one beat per
// cycle while in_tready is high, set by the single registered pass.
// Stall: a two-entry output buffer (result register plus skid register)
// keeps in_tready high for one more beat after out_tready drops; then
// in_tready goes low until the skid entry drains.
// Reset (rst_n low, synchronous): phase sleep, position 0, coils off, hold
// timer disarmed, hold_time_ms = 600, output buffer empty, in_tready low.
module stepper_valve_position_driver_unit #(
  parameter int POSITION_BITS = svpd_pkg::POSITION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: target_open [9:0], now_ms [41:10], zero pad [47:42]
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [svpd_pkg::IN_DATA_W-1:0]      in_tdata,
  // in_tuser: op [0]
  input  logic                                in_tuser,
  // out_tdata: coils [3:0], position [13:4], phase [15:14]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [svpd_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [svpd_pkg::HOLD_W-1:0]         cfg_data
);

  localparam int CW = (POSITION_BITS > svpd_pkg::POS_FIELD_W) ? POSITION_BITS
                                                              : svpd_pkg::POS_FIELD_W;

  svpd_pkg::ctl_t                    ctl_r;
  svpd_pkg::ctl_t                    ctl_nxt;
  logic [POSITION_BITS-1:0]          pos_r;
  logic [POSITION_BITS-1:0]          pos_nxt;
  logic [svpd_pkg::HOLD_W-1:0]       hold_time_r;

  logic [svpd_pkg::OUT_DATA_W-1:0]   out_tdata_r;
  logic                              out_tvalid_r;
  logic [svpd_pkg::OUT_DATA_W-1:0]   skid_tdata_r;
  logic                              skid_valid_r;

  logic                              in_accept;
  logic [svpd_pkg::TARGET_W-1:0]     in_target;
  logic [svpd_pkg::NOW_W-1:0]        in_now;
  logic [CW-1:0]                     pos_nxt_ext;
  logic [svpd_pkg::OUT_DATA_W-1:0]   result;

  // Take a beat whenever the skid entry is free; hold off during reset.
  assign in_tready = rst_n && !skid_valid_r;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign in_target = in_tdata[svpd_pkg::TARGET_W-1:0];
  assign in_now    = in_tdata[svpd_pkg::TARGET_W +: svpd_pkg::NOW_W];

  svpd_step #(
    .POSITION_BITS (POSITION_BITS)
  ) u_step (
    .ctl_i       (ctl_r),
    .pos_i       (pos_r),
    .op_i        (in_tuser),
    .target_i    (in_target),
    .now_i       (in_now),
    .hold_time_i (hold_time_r),
    .ctl_nxt     (ctl_nxt),
    .pos_nxt     (pos_nxt)
  );

  // Report the counter in the 10-bit position field.
  assign pos_nxt_ext = CW'(pos_nxt);
  assign result = {ctl_nxt.phase, pos_nxt_ext[svpd_pkg::POS_FIELD_W-1:0], ctl_nxt.coils};

  // Controller state and hold time register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r       <= '0;
      pos_r       <= '0;
      hold_time_r <= svpd_pkg::HOLD_TIME_RST;
    end else begin
      if (in_accept) begin
        ctl_r <= ctl_nxt;
        pos_r <= pos_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        hold_time_r <= cfg_data;
      end
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_tvalid_r || out_tready) begin
      // Output slot frees up: drain the skid entry first, else load the new beat.
      if (skid_valid_r) begin
        out_tvalid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_tvalid_r <= in_accept;
      end
    end else if (in_accept) begin
      // Receiver stalled: park the new result in the skid entry.
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_tvalid_r || out_tready) begin
      if (skid_valid_r) begin
        out_tdata_r <= skid_tdata_r;
      end else if (in_accept) begin
        out_tdata_r <= result;
      end
    end else if (in_accept) begin
      skid_tdata_r <= result;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`include "stepper_valve_position_driver_unit_assert.svh"

  `SVPD_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_r || out_tvalid_r, "skid entry full while output register empty")
  `SVPD_ASSERT_ALWAYS(a_armed_in_hold, !ctl_r.armed || ctl_r.phase == svpd_pkg::ST_START || ctl_r.phase == svpd_pkg::ST_STOP, "hold timer armed outside a hold phase")
  `SVPD_ASSERT_ALWAYS(a_sleep_coils_off, ctl_r.phase != svpd_pkg::ST_SLEEP || ctl_r.coils == '0, "coils energized in sleep")
  `SVPD_ASSERT_NEXT(a_step_beat, in_accept && !in_tuser && ctl_r.phase == svpd_pkg::ST_RUN && pos_nxt != pos_r, ctl_r.coils == svpd_pkg::beat_coils(pos_r[2:0]), "coil beat does not match stepped position")

endmodule

### test/valve_drive_checker.sv
`timescale 1ns / 100ps
module valve_drive_checker #(
  parameter int POSITION_BITS = svpd_pkg::POSITION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // in_tdata: target_open [9:0], now_ms [41:10], zero pad [47:42]
  input  logic [svpd_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: op [0]
  input  logic                            in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // out_tdata: coils [3:0], position [13:4], phase [15:14]
  input  logic [svpd_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [svpd_pkg::HOLD_W-1:0]     cfg_data,
  output int unsigned                     mismatch_count,
  output int unsigned                     backlog
);

  localparam logic [POSITION_BITS-1:0] POS_TOP = '1;
  // Half-step coil patterns, one nibble per beat, beat 0 in the low nibble.
  localparam logic [31:0] HALF_STEP_TABLE = 32'h98C4_6231;

  typedef struct packed {
    logic [svpd_pkg::PHASE_W-1:0]     phase;
    logic [svpd_pkg::POS_FIELD_W-1:0] position;
    logic [svpd_pkg::COIL_W-1:0]      coils;
  } drive_beat_t;

  logic [svpd_pkg::PHASE_W-1:0] mode_q;
  logic [POSITION_BITS-1:0]     pos_q;
  logic [svpd_pkg::COIL_W-1:0]  coil_q;
  logic [svpd_pkg::NOW_W-1:0]   hold_t0;
  logic                         hold_on;
  logic [svpd_pkg::HOLD_W-1:0]  hold_limit;

  drive_beat_t expected_drive[$];
  drive_beat_t got_beat;
  drive_beat_t want_beat;
  int unsigned fault_tally;
  int unsigned out_seq;

  function automatic logic [svpd_pkg::COIL_W-1:0] beat_of(input logic [POSITION_BITS-1:0] p);
    return HALF_STEP_TABLE[{p[2:0], 2'b00} +: 4];
  endfunction

  // Arm on the first call of a hold; expire once elapsed time exceeds the limit.
  function automatic logic hold_expired(input logic [svpd_pkg::NOW_W-1:0] now);
    logic [svpd_pkg::NOW_W-1:0] elapsed;
    if (!hold_on) begin
      hold_on = 1'b1;
      hold_t0 = now;
      return 1'b0;
    end
    elapsed = now - hold_t0;
    if (elapsed > svpd_pkg::NOW_W'(hold_limit)) begin
      hold_on = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void advance_valve(input logic op,
                                        input logic [svpd_pkg::TARGET_W-1:0] aim,
                                        input logic [svpd_pkg::NOW_W-1:0] now);
    logic [31:0]              wide_aim;
    logic [POSITION_BITS-1:0] goal;
    wide_aim = 32'(aim);
    if (wide_aim > 32'(POS_TOP)) goal = POS_TOP;
    else goal = POSITION_BITS'(wide_aim);
    if (op == svpd_pkg::OP_LOAD) begin
      pos_q = POSITION_BITS'(aim);
      return;
    end
    case (mode_q)
      svpd_pkg::ST_SLEEP: begin
        if (pos_q != goal) mode_q = svpd_pkg::ST_START;
      end
      svpd_pkg::ST_START: begin
        coil_q = beat_of(pos_q);
        if (hold_expired(now)) mode_q = svpd_pkg::ST_RUN;
      end
      svpd_pkg::ST_RUN: begin
        if (pos_q > goal) begin
          pos_q  = pos_q - 1'b1;
          coil_q = beat_of(pos_q);
        end else if (pos_q < goal) begin
          pos_q  = pos_q + 1'b1;
          coil_q = beat_of(pos_q);
        end else begin
          mode_q = svpd_pkg::ST_STOP;
        end
      end
      default: begin
        if (hold_expired(now)) begin
          coil_q = '0;
          mode_q = svpd_pkg::ST_SLEEP;
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fault_tally++;
    if (fault_tally <= 50)
      $display("chk: beat %0d %s: got 0x%0h, want 0x%0h (%0t)", out_seq, what, got, want,
               $time);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_q     = svpd_pkg::ST_SLEEP;
      pos_q      = '0;
      coil_q     = '0;
      hold_t0    = '0;
      hold_on    = 1'b0;
      hold_limit = svpd_pkg::HOLD_TIME_RST;
      expected_drive.delete();
    end else begin
      // Retire the result first: it always belongs to an older input beat.
      if (out_tvalid && out_tready) begin
        got_beat = out_tdata;
        if (expected_drive.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_tdata), 32'h0);
        end else begin
          want_beat = expected_drive.pop_front();
          if (got_beat.coils != want_beat.coils)
            report_mismatch("coils", 32'(got_beat.coils), 32'(want_beat.coils));
          if (got_beat.position != want_beat.position)
            report_mismatch("position", 32'(got_beat.position), 32'(want_beat.position));
          if (got_beat.phase != want_beat.phase)
            report_mismatch("phase", 32'(got_beat.phase), 32'(want_beat.phase));
        end
        out_seq++;
      end
      if (cfg_valid && cfg_ready) hold_limit = cfg_data;
      if (in_tvalid && in_tready) begin
        advance_valve(in_tuser, in_tdata[svpd_pkg::TARGET_W-1:0],
                      in_tdata[svpd_pkg::TARGET_W +: svpd_pkg::NOW_W]);
        want_beat.coils    = coil_q;
        want_beat.position = svpd_pkg::POS_FIELD_W'(pos_q);
        want_beat.phase    = mode_q;
        expected_drive.push_back(want_beat);
      end
    end
    backlog        <= expected_drive.size();
    mismatch_count <= fault_tally;
  end

endmodule

### test/stepper_valve_position_driver_unit_tb.sv
`timescale 1ns / 100ps
module stepper_valve_position_driver_unit_tb;

  // Cycles with no beat on any channel before the run is called hung.
  localparam int IDLE_LIMIT = 4000;
  // Input beats per hold-time setting in the random part.
  localparam int BEATS_PER_SETTING = 265;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  // target_open [9:0], now_ms [41:10], zero pad [47:42]
  logic [svpd_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                            in_tuser;   // op [0]
  logic                            out_tvalid;
  logic                            out_tready;
  // coils [3:0], position [13:4], phase [15:14]
  logic [svpd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [svpd_pkg::HOLD_W-1:0]     cfg_data;

  int unsigned mismatch_count;
  int unsigned backlog;

  // Stimulus state: the running millisecond clock, the last target and
  // the hold time currently programmed.
  logic [svpd_pkg::NOW_W-1:0]    clock_ms;
  logic [svpd_pkg::TARGET_W-1:0] aim;
  logic [svpd_pkg::HOLD_W-1:0]   hold_now;
  // Set for stretches with no idling on the sender or the receiver.
  logic                quiet_tx;
  logic                quiet_rx;
  int unsigned         stall_left = 0;
  int unsigned         idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  stepper_valve_position_driver_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  valve_drive_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .backlog        (backlog)
  );

  // Gap length: mostly short, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Time advance between calls: often right at the hold boundary so holds
  // end on the exact call that first exceeds the limit; rarely a wild jump.
  function automatic logic [svpd_pkg::NOW_W-1:0] next_step();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return svpd_pkg::NOW_W'(hold_now);
    if (r < 30) return svpd_pkg::NOW_W'(hold_now) + 1;
    if (r < 33) return $urandom();
    return $urandom_range(0, 2 * int'(hold_now) + 2);
  endfunction

  // Receiver: stall at random, hold out_tready low for the whole stall.
  always @(negedge clk) begin
    if (!rst_n || stall_left != 0) begin
      out_tready <= 1'b0;
      if (stall_left != 0) stall_left = stall_left - 1;
    end else if (!quiet_rx && $urandom_range(0, 99) < 18) begin
      stall_left = pick_gap() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog: end the run when no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offer one input beat, after an optional gap, and hold it until taken.
  // Enter and leave on a falling edge; tvalid stays high into the next beat.
  task automatic send_beat(input logic op, input logic [svpd_pkg::TARGET_W-1:0] tgt,
                           input logic [svpd_pkg::NOW_W-1:0] now);
    int unsigned gap;
    gap = 0;
    if (!quiet_tx && $urandom_range(0, 99) >= 65) gap = pick_gap();
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {{(svpd_pkg::IN_DATA_W - svpd_pkg::TARGET_W - svpd_pkg::NOW_W){1'b0}},
                 now, tgt};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Drop the input, wait for every expected result, then let the pipe empty.
  task automatic settle();
    in_tvalid = 1'b0;
    while (backlog != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_hold(input logic [svpd_pkg::HOLD_W-1:0] value);
    settle();
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    hold_now  = value;
  endtask

  // Random traffic for one hold setting: mostly full moves (optional load,
  // then a run of calls toward a nearby target with advancing time), plus
  // noise beats, mid-move loads and one-off retargets.
  task automatic run_setting(input int unsigned quota);
    int unsigned sent;
    int unsigned pick;
    int unsigned r;
    int          landing;
    logic [svpd_pkg::TARGET_W-1:0] origin;
    logic        pressured;
    sent      = 0;
    pressured = 1'b0;
    while (sent < quota) begin
      quiet_tx = ($urandom_range(0, 9) == 0);
      quiet_rx = ($urandom_range(0, 9) == 0);
      pick     = $urandom_range(0, 99);
      if (pick < 15) begin
        send_beat(1'($urandom_range(0, 1)), svpd_pkg::TARGET_W'($urandom_range(0, 1023)),
                  $urandom());
        sent++;
      end else begin
        origin = aim;
        if (pick < 55) begin
          origin = svpd_pkg::TARGET_W'($urandom_range(0, 1023));
          send_beat(svpd_pkg::OP_LOAD, origin, $urandom());
          sent++;
        end
        landing = int'(origin) + int'($urandom_range(0, 20)) - 10;
        if (landing < 0) landing = 0;
        if (landing > 1023) landing = 1023;
        aim = svpd_pkg::TARGET_W'(landing);
        repeat ($urandom_range(6, 28)) begin
          clock_ms = clock_ms + next_step();
          r = $urandom_range(0, 99);
          if (r < 4)
            send_beat(svpd_pkg::OP_LOAD, svpd_pkg::TARGET_W'($urandom_range(0, 1023)),
                      clock_ms);
          else if (r < 7)
            send_beat(svpd_pkg::OP_CALL, svpd_pkg::TARGET_W'($urandom_range(0, 1023)),
                      clock_ms);
          else send_beat(svpd_pkg::OP_CALL, aim, clock_ms);
          sent++;
        end
      end
      // Halfway through, hold the sender until every result is back.
      if (!pressured && sent >= quota / 2) begin
        settle();
        pressured = 1'b1;
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = svpd_pkg::OP_CALL;
    in_tdata   = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    quiet_tx   = 1'b0;
    quiet_rx   = 1'b0;
    hold_now   = svpd_pkg::HOLD_TIME_RST;
    aim        = '0;
    clock_ms   = 32'hFFFF_8000;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed part, reset hold time of 600 ms.
    send_beat(svpd_pkg::OP_LOAD, 10'd1023, 32'hFFFF_FFFF);   // load top position, time ignored
    send_beat(svpd_pkg::OP_CALL, 10'd1023, 32'd0);           // at target: stay asleep
    send_beat(svpd_pkg::OP_CALL, 10'd1021, 32'd0);           // off target: go to start
    send_beat(svpd_pkg::OP_CALL, 10'd1021, 32'd0);           // energize beat, arm at zero
    send_beat(svpd_pkg::OP_CALL, 10'd1021, 32'd600);         // elapsed equals limit: hold
    send_beat(svpd_pkg::OP_CALL, 10'd1021, 32'd601);         // elapsed past limit: run
    send_beat(svpd_pkg::OP_CALL, 10'd1021, 32'd601);         // step down
    send_beat(svpd_pkg::OP_CALL, 10'd1021, 32'd601);         // step down onto target
    send_beat(svpd_pkg::OP_CALL, 10'd1021, 32'd601);         // at target: stop
    send_beat(svpd_pkg::OP_CALL, 10'd1021, 32'hFFFF_FFFF);   // arm stop hold before wrap
    send_beat(svpd_pkg::OP_CALL, 10'd1021, 32'd599);         // wrapped elapsed 600: hold on
    send_beat(svpd_pkg::OP_CALL, 10'd1021, 32'd600);         // wrapped elapsed 601: off
    send_beat(svpd_pkg::OP_LOAD, 10'd0, 32'd0);              // load bottom position
    send_beat(svpd_pkg::OP_CALL, 10'd2, 32'd0);              // wake toward 2
    send_beat(svpd_pkg::OP_CALL, 10'd2, 32'd5);              // arm
    send_beat(svpd_pkg::OP_CALL, 10'd2, 32'd700);            // run
    send_beat(svpd_pkg::OP_CALL, 10'd2, 32'd700);            // step up
    send_beat(svpd_pkg::OP_LOAD, 10'd5, 32'd700);            // load mid-run
    send_beat(svpd_pkg::OP_CALL, 10'd2, 32'd700);            // step down from new position
    send_beat(svpd_pkg::OP_CALL, 10'd4, 32'd700);            // retarget to where it stands
    send_beat(svpd_pkg::OP_CALL, 10'd0, 32'd1000);           // arm stop hold, target ignored
    send_beat(svpd_pkg::OP_CALL, 10'd0, 32'd1601);           // hold over: sleep
    send_beat(svpd_pkg::OP_CALL, 10'd0, 32'd1601);           // off target again: start

    // Random part across hold settings, extremes included.
    run_setting(BEATS_PER_SETTING);
    write_hold(16'd0);
    run_setting(BEATS_PER_SETTING);
    write_hold(16'hFFFF);
    run_setting(BEATS_PER_SETTING);
    write_hold(16'd1);
    run_setting(BEATS_PER_SETTING);
    write_hold(svpd_pkg::HOLD_W'($urandom_range(2, 3000)));
    run_setting(BEATS_PER_SETTING);

    // Drain and give the verdict.
    in_tvalid = 1'b0;
    quiet_rx  = 1'b1;
    while (backlog != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && backlog == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
